// ===== design/kmdh_pkg.sv =====
// Package with shared constants and types for the k-way merge histogram core.
`timescale 1ns / 1ps
package kmdh_pkg;
    localparam int WAYS       = 16;
    localparam int NODE_BITS  = 32;
    localparam int COUNT_BITS = 32;
    localparam int IDX_BITS   = $clog2(WAYS);
    localparam int FILL_BITS  = $clog2(WAYS + 1);

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_EDGE = 2'd1;
    localparam logic [1:0] KIND_BIN  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_POP_RD,
        S_POP_WR,
        S_CLOSE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [NODE_BITS-1:0] src;
        logic [NODE_BITS-1:0] tgt;
        logic [3:0]           stream;
    } entry_t;
endpackage

// ===== design/kmdh_less.sv =====
// Shared comparator deciding whether one queue entry orders before another.
`timescale 1ns / 1ps
module kmdh_less
    import kmdh_pkg::*;
(
    input  entry_t a,
    input  entry_t b,
    output logic   less
);
    always_comb
    begin
        if (a.src != b.src)
            less = a.src < b.src;
        else if (a.tgt != b.tgt)
            less = a.tgt < b.tgt;
        else
            less = a.stream < b.stream;
    end
endmodule

// ===== design/kway_merge_duplicate_histogram_core.sv =====
// Top level of the k-way merge queue with duplicate-run histogram.
`timescale 1ns / 1ps
// Channel  | Ports                                            | Handshake
// command  | start, busy, opcode, edge_source, edge_target,   | start && !busy
//          | stream_index                                     |
// result   | result_valid, kind, status, out_source,          | result_valid, one
//          | out_target, out_stream, bin_multiplicity,        | cycle per transfer
//          | bin_count, last_of_run                           |
// A load, an empty pop and an unused opcode never raise busy; a load or an empty pop is
// acknowledged in the cycle after the transfer, and an unused opcode yields no result.
// A pop scans the queue one entry per cycle through the shared comparator, then moves
// the tail entry into the hole; its edge shows in the last busy cycle. A finish first
// closes the open run, then emits one histogram bin per cycle, the last bin showing
// in the first idle cycle. Reset is asynchronous and clears control state and the
// histogram. The receiver cannot stall, so every result leaves in the cycle it is shown.
module kway_merge_duplicate_histogram_core
    import kmdh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            opcode,
    input  logic [NODE_BITS-1:0]  edge_source,
    input  logic [NODE_BITS-1:0]  edge_target,
    input  logic [3:0]            stream_index,
    output logic                  result_valid,
    output logic [1:0]            kind,
    output logic [1:0]            status,
    output logic [31:0]           out_source,
    output logic [31:0]           out_target,
    output logic [3:0]            out_stream,
    output logic [4:0]            bin_multiplicity,
    output logic [31:0]           bin_count,
    output logic                  last_of_run
);
    // Queue storage; only entries below the fill count are ever used.
    entry_t queue_mem [WAYS];

    state_t state_reg, state_next;
    logic [FILL_BITS-1:0]  fill_reg;
    logic [IDX_BITS-1:0]   scan_reg, best_reg;
    entry_t                best_e_reg, last_e_reg;
    logic [NODE_BITS-1:0]  run_src_reg, run_tgt_reg;
    logic                  run_open_reg;
    logic [FILL_BITS-1:0]  run_len_reg;
    logic [COUNT_BITS-1:0] bins_reg [WAYS];
    logic [IDX_BITS-1:0]   emit_reg;

    entry_t scan_e;
    logic   scan_less;

    logic                  rv_reg;
    logic [1:0]            kind_reg, status_reg;
    entry_t                oe_reg;
    logic [4:0]            mult_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic                  last_reg;

    assign scan_e = queue_mem[scan_reg];

    kmdh_less u_less (.a(scan_e), .b(best_e_reg), .less(scan_less));

    logic [IDX_BITS-1:0] close_idx;
    always_comb
    begin
        if (run_len_reg == '0)
            close_idx = '0;
        else
            close_idx = IDX_BITS'(run_len_reg - 1'b1);
    end

    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_POP:
                            state_next = (fill_reg == '0) ? S_IDLE : S_SCAN;
                        OP_FINISH: state_next = S_CLOSE;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (FILL_BITS'(scan_reg) + 1'b1 >= fill_reg)
                    state_next = S_POP_RD;
            end
            S_POP_RD: state_next = S_POP_WR;
            S_POP_WR: state_next = S_IDLE;
            S_CLOSE:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (emit_reg == IDX_BITS'(WAYS - 1))
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Queue memory writes: load appends, pop moves the tail into the hole.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept && opcode == OP_LOAD
            && fill_reg < FILL_BITS'(WAYS))
            queue_mem[fill_reg[IDX_BITS-1:0]] <=
                '{src: edge_source, tgt: edge_target, stream: stream_index};
        else if (state_reg == S_POP_WR)
            queue_mem[best_reg] <= last_e_reg;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                scan_reg   <= IDX_BITS'(1);
                best_reg   <= '0;
                best_e_reg <= queue_mem[0];
            end
            S_SCAN:
            begin
                if (FILL_BITS'(scan_reg) < fill_reg && scan_less)
                begin
                    best_reg   <= scan_reg;
                    best_e_reg <= scan_e;
                end
                scan_reg <= scan_reg + 1'b1;
            end
            S_POP_RD:
                last_e_reg <= queue_mem[IDX_BITS'(fill_reg - 1'b1)];
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            run_src_reg  <= '0;
            run_tgt_reg  <= '0;
            run_open_reg <= 1'b0;
            run_len_reg  <= '0;
            emit_reg     <= '0;
            for (int i = 0; i < WAYS; i++)
                bins_reg[i] <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    emit_reg <= '0;
                    if (accept && opcode == OP_LOAD && fill_reg < FILL_BITS'(WAYS))
                        fill_reg <= fill_reg + 1'b1;
                end
                S_POP_RD:
                begin
                    fill_reg <= fill_reg - 1'b1;
                    if (run_open_reg && best_e_reg.src == run_src_reg
                        && best_e_reg.tgt == run_tgt_reg)
                    begin
                        if (run_len_reg < FILL_BITS'(WAYS))
                            run_len_reg <= run_len_reg + 1'b1;
                    end
                    else
                    begin
                        if (run_open_reg && bins_reg[close_idx] != '1)
                            bins_reg[close_idx] <= bins_reg[close_idx] + 1'b1;
                        run_open_reg <= 1'b1;
                        run_src_reg  <= best_e_reg.src;
                        run_tgt_reg  <= best_e_reg.tgt;
                        run_len_reg  <= FILL_BITS'(1);
                    end
                end
                S_CLOSE:
                begin
                    if (run_open_reg && bins_reg[close_idx] != '1)
                        bins_reg[close_idx] <= bins_reg[close_idx] + 1'b1;
                    run_open_reg <= 1'b0;
                    run_src_reg  <= '0;
                    run_tgt_reg  <= '0;
                    run_len_reg  <= '0;
                end
                S_EMIT:
                begin
                    bins_reg[emit_reg] <= '0;
                    emit_reg <= emit_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result register: one transfer per strobe, zero in unused fields; last_of_run is one outside bins.
    // From idle only a load or a pop on an empty queue answers at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= 1'b0;
        else
            rv_reg <= (state_reg == S_IDLE && accept
                       && (opcode == OP_LOAD || (opcode == OP_POP && fill_reg == '0)))
                      || state_reg == S_POP_RD || state_reg == S_EMIT;
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= KIND_ACK;
        status_reg <= ST_OK;
        oe_reg     <= '0;
        mult_reg   <= '0;
        cnt_reg    <= '0;
        last_reg   <= 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (opcode == OP_LOAD)
                    status_reg <= (fill_reg >= FILL_BITS'(WAYS)) ? ST_FULL : ST_OK;
                else
                begin
                    kind_reg   <= KIND_EDGE;
                    status_reg <= ST_EMPTY;
                end
            end
            S_POP_RD:
            begin
                kind_reg <= KIND_EDGE;
                oe_reg   <= best_e_reg;
            end
            S_EMIT:
            begin
                kind_reg <= KIND_BIN;
                mult_reg <= 5'(emit_reg) + 5'd1;
                cnt_reg  <= bins_reg[emit_reg];
                last_reg <= (emit_reg == IDX_BITS'(WAYS - 1));
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid     = rv_reg;
    assign kind             = kind_reg;
    assign status           = status_reg;
    assign out_source       = oe_reg.src;
    assign out_target       = oe_reg.tgt;
    assign out_stream       = oe_reg.stream;
    assign bin_multiplicity = mult_reg;
    assign bin_count        = cnt_reg;
    assign last_of_run      = last_reg;
endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the k-way merge queue with duplicate-run histogram.
`timescale 1ns / 1ps
module testbench;
    import kmdh_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           opcode;
    logic [NODE_BITS-1:0] edge_source;
    logic [NODE_BITS-1:0] edge_target;
    logic [3:0]           stream_index;
    logic                 result_valid;
    logic [1:0]           kind;
    logic [1:0]           status;
    logic [31:0]          out_source;
    logic [31:0]          out_target;
    logic [3:0]           out_stream;
    logic [4:0]           bin_multiplicity;
    logic [31:0]          bin_count;
    logic                 last_of_run;

    kway_merge_duplicate_histogram_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .opcode(opcode),
        .edge_source(edge_source), .edge_target(edge_target),
        .stream_index(stream_index), .result_valid(result_valid), .kind(kind),
        .status(status), .out_source(out_source), .out_target(out_target),
        .out_stream(out_stream), .bin_multiplicity(bin_multiplicity),
        .bin_count(bin_count), .last_of_run(last_of_run)
    );

    // One expected result, laid out like the result ports.
    typedef struct {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [31:0] src;
        logic [31:0] tgt;
        logic [3:0]  stream;
        logic [4:0]  mult;
        logic [31:0] count;
        logic        last;
    } result_t;

    result_t expected_results[$];

    // Shadow copy of the block's state.
    entry_t               shadow_queue[WAYS];
    int                   shadow_fill;
    logic [NODE_BITS-1:0] cur_run_src;
    logic [NODE_BITS-1:0] cur_run_tgt;
    bit                   cur_run_open;
    int                   cur_run_len;
    logic [31:0]          shadow_bins[WAYS];

    int error_count;
    int sender_idle_pct;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic result_t make_result(logic [1:0] k, logic [1:0] st,
                                            logic [31:0] s, logic [31:0] t,
                                            logic [3:0] sm, logic [4:0] m,
                                            logic [31:0] c, logic l);
        result_t r;
        r.kind = k; r.status = st; r.src = s; r.tgt = t; r.stream = sm;
        r.mult = m; r.count = c; r.last = l;
        return r;
    endfunction

    // Appends one expectation behind the ones still outstanding.
    function automatic void add_expected(result_t r);
        expected_results = {expected_results, r};
    endfunction

    // Closes the open run into its histogram bin, saturating the count.
    function automatic void close_open_run();
        int len;
        if (!cur_run_open) return;
        len = (cur_run_len < 1) ? 1 : ((cur_run_len > WAYS) ? WAYS : cur_run_len);
        if (shadow_bins[len-1] != '1) shadow_bins[len-1]++;
    endfunction

    // Works out the results of one accepted command and updates the shadow state.
    function automatic void predict_merge_results(logic [1:0] op, logic [31:0] s,
                                                  logic [31:0] t, logic [3:0] sm);
        int   best;
        entry_t e;
        if (op == OP_LOAD) begin
            if (shadow_fill >= WAYS) begin
                add_expected(make_result(KIND_ACK, ST_FULL, 0, 0, 0, 0, 0, 1));
            end
            else begin
                shadow_queue[shadow_fill] = '{src: s, tgt: t, stream: sm};
                shadow_fill++;
                add_expected(make_result(KIND_ACK, ST_OK, 0, 0, 0, 0, 0, 1));
            end
        end
        else if (op == OP_POP) begin
            if (shadow_fill == 0) begin
                add_expected(make_result(KIND_EDGE, ST_EMPTY, 0, 0, 0, 0, 0, 1));
                return;
            end
            best = 0;
            for (int i = 1; i < shadow_fill; i++)
                if ({shadow_queue[i].src, shadow_queue[i].tgt, shadow_queue[i].stream} <
                    {shadow_queue[best].src, shadow_queue[best].tgt,
                     shadow_queue[best].stream})
                    best = i;
            e = shadow_queue[best];
            shadow_fill--;
            shadow_queue[best] = shadow_queue[shadow_fill];
            if (cur_run_open && e.src == cur_run_src && e.tgt == cur_run_tgt) begin
                if (cur_run_len < WAYS) cur_run_len++;
            end
            else begin
                close_open_run();
                cur_run_open = 1;
                cur_run_src  = e.src;
                cur_run_tgt  = e.tgt;
                cur_run_len  = 1;
            end
            add_expected(make_result(KIND_EDGE, ST_OK, e.src, e.tgt,
                                     e.stream, 0, 0, 1));
        end
        else if (op == OP_FINISH) begin
            close_open_run();
            for (int m = 1; m <= WAYS; m++)
                add_expected(make_result(KIND_BIN, ST_OK, 0, 0, 0, m[4:0],
                                         shadow_bins[m-1], m == WAYS));
            foreach (shadow_bins[i]) shadow_bins[i] = '0;
            cur_run_open = 0;
            cur_run_src  = '0;
            cur_run_tgt  = '0;
            cur_run_len  = 0;
        end
        // The unused opcode is ignored by the block and yields nothing.
    endfunction

    // Every result is compared with the oldest expectation at the edge that ends it.
    always @(posedge clk) begin
        result_t w;
        if (rst_n && result_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result kind", 32'(kind), 32'(0));
            end
            else begin
                w = expected_results.pop_front();
                if (kind !== w.kind) report_mismatch("kind", kind, w.kind);
                if (status !== w.status) report_mismatch("status", status, w.status);
                if (out_source !== w.src) report_mismatch("out_source", out_source, w.src);
                if (out_target !== w.tgt) report_mismatch("out_target", out_target, w.tgt);
                if (out_stream !== w.stream) report_mismatch("out_stream", out_stream, w.stream);
                if (bin_multiplicity !== w.mult)
                    report_mismatch("bin_multiplicity", bin_multiplicity, w.mult);
                if (bin_count !== w.count) report_mismatch("bin_count", bin_count, w.count);
                if (last_of_run !== w.last) report_mismatch("last_of_run", last_of_run, w.last);
            end
        end
    end

    // Sends one command: optional random idle, then holds start until the transfer.
    // Start stays high afterwards; the next command or the drain wait drives it again.
    task automatic send_command(input logic [1:0] op, input logic [31:0] s,
                                input logic [31:0] t, input logic [3:0] sm);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        opcode       <= op;
        edge_source  <= s;
        edge_target  <= t;
        stream_index <= sm;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_merge_results(op, s, t, sm);
    endtask

    task automatic wait_until_drained();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    // Extremes of the node fields, an empty pop, an unused opcode and an empty finish.
    task automatic test_directed_corners();
        send_command(OP_POP, 0, 0, 0);
        send_command(OP_FINISH, 0, 0, 0);
        send_command(OP_NONE, '1, '1, 4'hf);
        send_command(OP_LOAD, '1, '1, 4'hf);
        send_command(OP_LOAD, 0, 0, 0);
        send_command(OP_LOAD, '1, '1, 4'h0);
        send_command(OP_LOAD, 32'h5555_aaaa, 32'haaaa_5555, 4'h5);
        send_command(OP_POP, 0, 0, 0);
        send_command(OP_POP, 0, 0, 0);
        send_command(OP_POP, 0, 0, 0);
        send_command(OP_POP, 0, 0, 0);
        send_command(OP_FINISH, 0, 0, 0);
        wait_until_drained();
    endtask

    // Loads past a full queue with one repeated edge, so the run reaches the longest bin.
    task automatic test_full_and_long_run();
        for (int i = 0; i < WAYS + 2; i++)
            send_command(OP_LOAD, 32'h7, 32'h9, i[3:0]);
        for (int i = 0; i < WAYS + 1; i++)
            send_command(OP_POP, 0, 0, 0);
        send_command(OP_FINISH, 0, 0, 0);
        wait_until_drained();
    endtask

    // Merges small batches drawn from narrow id ranges, so duplicates are common.
    task automatic test_random_merges(input int n_items);
        int sent;
        int sel;
        int span;
        logic [31:0] s;
        logic [31:0] t;
        sent = 0;
        while (sent < n_items) begin
            span = $urandom_range(3) == 0 ? 0 : 3;
            repeat ($urandom_range(WAYS + 2, 1)) begin
                sel = $urandom_range(9);
                if (sel == 0) begin
                    s = $urandom; t = $urandom;
                end
                else begin
                    s = $urandom_range(span); t = $urandom_range(span);
                end
                send_command(OP_LOAD, s, t, 4'($urandom));
                sent++;
            end
            repeat ($urandom_range(WAYS + 2, 1)) begin
                send_command($urandom_range(15) == 0 ? OP_NONE : OP_POP, $urandom, $urandom,
                             4'($urandom));
                sent++;
            end
            if ($urandom_range(3) == 0) begin
                send_command(OP_FINISH, $urandom, $urandom, 4'($urandom));
                sent++;
            end
            // Once in a while hold off until everything outstanding has come back.
            if ($urandom_range(7) == 0) wait_until_drained();
        end
        send_command(OP_FINISH, 0, 0, 0);
    endtask

    initial begin
        error_count     = 0;
        sender_idle_pct = 9;
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = OP_LOAD;
        edge_source  = '0;
        edge_target  = '0;
        stream_index = '0;
        shadow_fill  = 0;
        cur_run_open = 0;
        cur_run_src  = '0;
        cur_run_tgt  = '0;
        cur_run_len  = 0;
        foreach (shadow_bins[i]) shadow_bins[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_full_and_long_run();
        test_random_merges(100);
        sender_idle_pct = 55;
        test_random_merges(100);
        sender_idle_pct = 0;
        test_random_merges(100);
        wait_until_drained();

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ===== kway_merge_duplicate_histogram_core.f =====
design/kmdh_pkg.sv
design/kmdh_less.sv
design/kway_merge_duplicate_histogram_core.sv
test/testbench.sv
